/* hdl/lutf8_pkg.sv */
// Shared types and constants for the lenient UTF-8 decoder.
`default_nettype none
package lutf8_pkg;

	localparam int unsigned CP_W      = 21;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned EXP_W     = 2;
	localparam int unsigned QDEPTH    = 4;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);
	localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic [1:0] CONT_TAG   = 2'b10;
	localparam logic [7:0] LEAD4_MIN  = 8'hf0;
	localparam logic [7:0] LEAD3_MIN  = 8'he0;
	localparam logic [5:0] CONT_MASK  = 6'h3f;
	localparam logic [6:0] ASCII_MASK = 7'h7f;

	typedef struct packed {
		logic [CP_W-1:0] code_point;
		logic            last_of_run;
	} result_t;

endpackage
`default_nettype wire

/* hdl/lenient_utf8_decoder_core.sv */
// Lenient streaming UTF-8 decoder: bytes in, code points out through a result queue.
`default_nettype none
// One byte is taken per cycle whenever the result queue has room for two results;
// each accepted byte is decoded in the same cycle and its zero, one or two code
// points are written into a four-entry result queue, which delivers one code point
// per cycle while out_ready is high. The output side therefore sets the sustained
// rate: one byte per cycle while bytes give at most one result each, and one result
// per cycle when an early-ended sequence makes a byte give two. A stray continuation
// byte gives no result, and a zero byte flushes any pending, possibly short, value.
module lenient_utf8_decoder_core
	import lutf8_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [BYTE_W-1:0]     text_byte,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [CP_W-1:0]       code_point,
	output logic                  last_of_run
);

	logic [CP_W-1:0]   pv_q;
	logic [EXP_W-1:0]  exp_q;
	logic [CP_W-1:0]   pv_d;
	logic [EXP_W-1:0]  exp_d;

	result_t           queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	logic              in_fire;
	logic              out_fire;
	logic [1:0]        push_n;
	result_t           res0;
	result_t           res1;
	logic [EXP_W-1:0]  extra;
	logic [CP_W-1:0]   shifted;
	logic [EXP_W-1:0]  exp_dec;
	logic [QPTR_W-1:0] wr_next;

	assign in_ready  = (cnt_q <= QCNT_W'(QDEPTH - 2));
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (cnt_q != '0);
	assign out_fire  = out_valid && out_ready;
	assign code_point  = queue_q[rd_q].code_point;
	assign last_of_run = queue_q[rd_q].last_of_run;

	assign shifted = {pv_q[CP_W-7:0], text_byte[5:0] & CONT_MASK};
	assign exp_dec = exp_q - EXP_W'(1);
	assign wr_next = wr_q + QPTR_W'(1);

	always_comb begin
		if (text_byte >= LEAD4_MIN) begin
			extra = 2'd3;
		end else if (text_byte >= LEAD3_MIN) begin
			extra = 2'd2;
		end else begin
			extra = 2'd1;
		end
	end

	always_comb begin
		pv_d   = pv_q;
		exp_d  = exp_q;
		push_n = 2'd0;
		res0   = '{code_point: pv_q, last_of_run: 1'b0};
		res1   = '{code_point: pv_q, last_of_run: 1'b1};
		if (text_byte[7:6] == CONT_TAG) begin
			if (exp_q != '0) begin
				exp_d = exp_dec;
				if (exp_dec == '0) begin
					res0   = '{code_point: shifted, last_of_run: 1'b1};
					push_n = 2'd1;
					pv_d   = '0;
				end else begin
					pv_d = shifted;
				end
			end
		end else begin
			pv_d  = '0;
			exp_d = '0;
			if (text_byte == '0) begin
				res0.last_of_run = 1'b1;
				push_n = (exp_q != '0) ? 2'd1 : 2'd0;
			end else if (!text_byte[7]) begin
				if (exp_q != '0) begin
					push_n = 2'd2;
					res1   = '{code_point: CP_W'(text_byte[6:0] & ASCII_MASK),
						last_of_run: 1'b1};
				end else begin
					push_n = 2'd1;
					res0   = '{code_point: CP_W'(text_byte[6:0] & ASCII_MASK),
						last_of_run: 1'b1};
				end
			end else begin
				res0.last_of_run = 1'b1;
				push_n = (exp_q != '0) ? 2'd1 : 2'd0;
				pv_d   = CP_W'(text_byte[5:0] & (CONT_MASK >> extra));
				exp_d  = extra;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= '0;
			exp_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (in_fire) begin
				pv_q  <= pv_d;
				exp_q <= exp_d;
				wr_q  <= wr_q + QPTR_W'(push_n);
			end
			if (out_fire) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(in_fire ? push_n : 2'd0) - QCNT_W'(out_fire);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && push_n != 2'd0) begin
			queue_q[wr_q] <= res0;
		end
		if (in_fire && push_n == 2'd2) begin
			queue_q[wr_next] <= res1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("result queue count out of range");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		exp_q == '0 |-> pv_q == '0)
		else $error("partial value held with nothing pending");

	a_zero_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && text_byte == '0 |=> exp_q == '0)
		else $error("zero byte did not flush pending sequence");

	a_lead_pend: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && text_byte[7:6] == 2'b11 |=> exp_q != '0)
		else $error("lead byte did not start a sequence");

	a_ptr_sync: assert property (@(posedge clk) disable iff (!arst_n)
		QPTR_W'(wr_q - rd_q) == QPTR_W'(cnt_q))
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for the lenient UTF-8 decoder: byte stream in, checked code points out.
`timescale 1ns / 1ps
module tb_top
	import lutf8_pkg::*;
();

	localparam logic [7:0] LEAD2_MIN  = 8'hc0;
	localparam int         STALL_CAP  = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [BYTE_W-1:0] text_byte = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CP_W-1:0]   code_point;
	logic              last_of_run;

	logic [BYTE_W-1:0] bytes_pending[$];
	result_t           points_due[$];
	logic [CP_W-1:0]   acc_point = '0;
	logic [EXP_W-1:0]  conts_left = '0;

	bit byte_taken = 1'b0;
	int send_gap_pct = 12;
	int take_gap_pct = 83;
	int idle_cycles = 0;
	int mismatches = 0;
	int bytes_sent = 0;
	int points_checked = 0;
	int cut_short = 0;
	int double_points = 0;

	lenient_utf8_decoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.text_byte(text_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.code_point(code_point),
		.last_of_run(last_of_run)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("tb_top: mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic void add_byte(input logic [BYTE_W-1:0] b);
		bytes_pending.insert(bytes_pending.size(), b);
	endfunction

	function automatic void add_point(input result_t p);
		points_due.insert(points_due.size(), p);
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		result_t         flushed;
		result_t         point;
		bit              have_flush;
		logic [EXP_W-1:0] extra;
		have_flush = 1'b0;
		flushed = '0;
		if (b[7:6] == CONT_TAG) begin
			if (conts_left == 0)
				return;
			acc_point = {acc_point[CP_W-7:0], b[5:0] & CONT_MASK};
			conts_left = conts_left - 1'b1;
			if (conts_left == 0) begin
				point.code_point = acc_point;
				point.last_of_run = 1'b1;
				add_point(point);
				acc_point = '0;
			end
			return;
		end
		if (conts_left != 0) begin
			flushed.code_point = acc_point;
			have_flush = 1'b1;
			acc_point = '0;
			conts_left = '0;
			cut_short++;
		end
		if (b == 8'h00 || b >= LEAD2_MIN) begin
			if (have_flush) begin
				flushed.last_of_run = 1'b1;
				add_point(flushed);
			end
			if (b != 8'h00) begin
				extra = (b >= LEAD4_MIN) ? 2'd3 : (b >= LEAD3_MIN) ? 2'd2 : 2'd1;
				acc_point = CP_W'(b & (8'h3f >> extra));
				conts_left = extra;
			end
		end else begin
			if (have_flush) begin
				flushed.last_of_run = 1'b0;
				add_point(flushed);
				double_points++;
			end
			point.code_point = CP_W'(b[6:0] & ASCII_MASK);
			point.last_of_run = 1'b1;
			add_point(point);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			byte_taken = in_valid && in_ready;
			if (out_valid && out_ready) begin
				if (points_due.size() == 0) begin
					report_mismatch($sformatf("code point %h with nothing pending", code_point));
				end else begin
					want = points_due.pop_front();
					points_checked++;
					if (code_point !== want.code_point)
						report_mismatch($sformatf("code_point %h, want %h",
							code_point, want.code_point));
					if (last_of_run !== want.last_of_run)
						report_mismatch($sformatf("last_of_run %b, want %b on point %h",
							last_of_run, want.last_of_run, want.code_point));
				end
			end
			if (byte_taken) begin
				decode_byte(text_byte);
				bytes_sent++;
			end
			idle_cycles = (byte_taken || (out_valid && out_ready)) ? 0 : idle_cycles + 1;
		end else begin
			idle_cycles = idle_cycles + 1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || byte_taken) begin
				if (bytes_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					in_valid <= 1'b1;
					text_byte <= bytes_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= take_gap_pct);
		end
	end

	task automatic queue_random_text(input int count);
		int made;
		int pick;
		int conts;
		int k;
		logic [7:0] lead;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				add_byte(8'($urandom_range(1, 127)));
				made++;
			end else if (pick < 85) begin
				if (pick < 45)
					lead = 8'($urandom_range(8'hc0, 8'hdf));
				else if (pick < 60)
					lead = 8'($urandom_range(8'he0, 8'hef));
				else if (pick < 75)
					lead = 8'($urandom_range(8'hf0, 8'hff));
				else
					lead = 8'($urandom_range(8'hc0, 8'hff));
				conts = (lead >= LEAD4_MIN) ? 3 : (lead >= LEAD3_MIN) ? 2 : 1;
				if (pick >= 75)
					conts = $urandom_range(0, conts - 1);
				add_byte(lead);
				for (k = 0; k < conts; k++)
					add_byte(8'($urandom_range(8'h80, 8'hbf)));
				made += 1 + conts;
				if (pick >= 75 && $urandom_range(0, 2) == 0) begin
					add_byte(8'h00);
					made++;
				end
			end else if (pick < 92) begin
				add_byte(8'($urandom_range(8'h80, 8'hbf)));
				made++;
			end else begin
				add_byte(8'h00);
				made++;
			end
		end
	endtask

	task automatic drain_all;
		while (bytes_pending.size() != 0 || in_valid)
			@(posedge clk);
		while (points_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int send_pct, input int take_pct, input int count);
		send_gap_pct = send_pct;
		take_gap_pct = take_pct;
		queue_random_text(count / 2);
		drain_all();
		queue_random_text(count - count / 2);
		drain_all();
	endtask

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_byte(8'h00);
		add_byte(8'h01);
		add_byte(8'h7f);
		add_byte(8'h80);
		add_byte(8'hc0); add_byte(8'h80);
		add_byte(8'he0); add_byte(8'h80);
		add_byte(8'h80);
		add_byte(8'hf0); add_byte(8'h80);
		add_byte(8'h80); add_byte(8'h80);
		add_byte(8'hff); add_byte(8'hbf);
		add_byte(8'hbf); add_byte(8'hbf);
		add_byte(8'hc3); add_byte(8'he2);
		add_byte(8'h41);
		add_byte(8'hf0); add_byte(8'h90);
		add_byte(8'h00);
		drain_all();

		run_phase(12, 83, 600);
		run_phase(83, 12, 600);
		run_phase(0, 0, 625);

		repeat (16) @(posedge clk);
		$display("tb_top: %0d bytes sent, %0d code points checked, %0d mismatches",
			bytes_sent, points_checked, mismatches);
		$display("tb_top: %0d sequences cut short, %0d bytes gave two code points",
			cut_short, double_points);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		while (idle_cycles < STALL_CAP)
			@(posedge clk);
		$display("tb_top: stalled for %0d cycles, %0d code points outstanding",
			idle_cycles, points_due.size());
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/lutf8_pkg.sv
hdl/lenient_utf8_decoder_core.sv
bench/tb_top.sv
